### design/extended_euclid_gcd_macros.svh
// Assertion macros used by the extended Euclid gcd design.
`ifndef EXTENDED_EUCLID_GCD_MACROS_SVH
`define EXTENDED_EUCLID_GCD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EEG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EEG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/eeg_pkg.sv
// Shared types and constants for the extended Euclid gcd design.
package eeg_pkg;

  localparam int COEF_WIDTH         = 32;
  localparam int DEF_OPERAND_WIDTH  = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

### design/eeg_divider.sv
// Radix-2 restoring divider that also accumulates quotient times two coefficients.
module eeg_divider #(
  parameter int WIDTH = eeg_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  eeg_pkg::div_ctl_t              ctl,
  input  logic [WIDTH-1:0]               dividend,
  input  logic [WIDTH-1:0]               divisor,
  input  logic [eeg_pkg::COEF_WIDTH-1:0] x_mult,
  input  logic [eeg_pkg::COEF_WIDTH-1:0] w_mult,
  output logic [WIDTH-1:0]               remainder,
  output logic [eeg_pkg::COEF_WIDTH-1:0] x_prod,
  output logic [eeg_pkg::COEF_WIDTH-1:0] w_prod,
  output eeg_pkg::div_sts_t              sts
);

  localparam int CW = $clog2(WIDTH + 1);

  logic                           busy;
  logic                           done;
  logic [CW-1:0]                  cnt;
  logic [WIDTH-1:0]               rem;
  logic [WIDTH-1:0]               dvd;
  logic [WIDTH-1:0]               dsr;
  logic [eeg_pkg::COEF_WIDTH-1:0] xm;
  logic [eeg_pkg::COEF_WIDTH-1:0] wm;
  logic [eeg_pkg::COEF_WIDTH-1:0] px;
  logic [eeg_pkg::COEF_WIDTH-1:0] pw;

  logic [WIDTH:0]                 shifted;
  logic [WIDTH:0]                 trial;
  logic                           qbit;

  assign shifted = {rem, dvd[WIDTH-1]};
  assign trial   = shifted - {1'b0, dsr};
  assign qbit    = ~trial[WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(WIDTH);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
      xm  <= x_mult;
      wm  <= w_mult;
      px  <= '0;
      pw  <= '0;
    end else if (busy) begin
      rem <= qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
      dvd <= dvd << 1;
      px  <= (px << 1) + (qbit ? xm : '0);
      pw  <= (pw << 1) + (qbit ? wm : '0);
    end
  end

  assign remainder = rem;
  assign x_prod    = px;
  assign w_prod    = pw;
  assign sts.busy  = busy;
  assign sts.done  = done;

endmodule

### design/extended_euclid_gcd.sv
// Top level of the extended Euclid gcd block with its sequencer.
// The input channel carries a word of two operands, a_value and b_value,
// under in_valid and in_stall. The output channel carries a word of the gcd
// and the two Bezout coefficients under out_valid and out_stall; coef_a and
// coef_b are two's complement and wrap modulo 2^32 for wide operands.
// One word is processed at a time: in_stall is high from acceptance until
// the result has been moved into the output register.
// Each Euclid iteration runs one shared radix-2 divider, which also forms
// the quotient times both coefficients, between the start and update
// states of the sequencer. For 31-bit operands the loop runs at most about
// 46 iterations. A zero b_value skips the loop and goes straight to the
// done state. From the done state the result moves into the output
// register and the sequencer returns to idle to accept the next word.
// When the receiver stalls, the result waits in the output register and
// the block holds the next result, not accepting a new word, until the
// output register is free. A synchronous reset returns to idle and drops
// any word in flight or waiting at the output.
`include "extended_euclid_gcd_macros.svh"

module extended_euclid_gcd #(
  parameter int OPERAND_WIDTH = eeg_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [OPERAND_WIDTH-1:0]              a_value,
  input  logic [OPERAND_WIDTH-1:0]              b_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [OPERAND_WIDTH-1:0]              gcd_value,
  output logic signed [eeg_pkg::COEF_WIDTH-1:0] coef_a,
  output logic signed [eeg_pkg::COEF_WIDTH-1:0] coef_b
);

  eeg_pkg::state_t                state;
  eeg_pkg::state_t                state_next;
  eeg_pkg::div_ctl_t              div_ctl;
  eeg_pkg::div_sts_t              div_sts;

  logic [OPERAND_WIDTH-1:0]       g;
  logic [OPERAND_WIDTH-1:0]       y;
  logic [eeg_pkg::COEF_WIDTH-1:0] u;
  logic [eeg_pkg::COEF_WIDTH-1:0] x;
  logic [eeg_pkg::COEF_WIDTH-1:0] v;
  logic [eeg_pkg::COEF_WIDTH-1:0] w;

  logic [OPERAND_WIDTH-1:0]       div_rem;
  logic [eeg_pkg::COEF_WIDTH-1:0] x_prod;
  logic [eeg_pkg::COEF_WIDTH-1:0] w_prod;

  logic                           in_take;
  logic                           load_out;

  eeg_divider #(
    .WIDTH(OPERAND_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (g),
    .divisor  (y),
    .x_mult   (x),
    .w_mult   (w),
    .remainder(div_rem),
    .x_prod   (x_prod),
    .w_prod   (w_prod),
    .sts      (div_sts)
  );

  always_comb begin
    state_next = state;
    case (state)
      eeg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (b_value == '0) ? eeg_pkg::ST_DONE : eeg_pkg::ST_START;
        end
      end
      eeg_pkg::ST_START: begin
        state_next = eeg_pkg::ST_DIV;
      end
      eeg_pkg::ST_DIV: begin
        if (div_sts.done) begin
          state_next = eeg_pkg::ST_UPDATE;
        end
      end
      eeg_pkg::ST_UPDATE: begin
        state_next = (div_rem == '0) ? eeg_pkg::ST_DONE : eeg_pkg::ST_START;
      end
      eeg_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = eeg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = eeg_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    div_ctl.start = 1'b0;
    load_out      = 1'b0;
    case (state)
      eeg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      eeg_pkg::ST_START: begin
        div_ctl.start = 1'b1;
      end
      eeg_pkg::ST_DONE: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eeg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      g <= a_value;
      y <= b_value;
      u <= eeg_pkg::COEF_WIDTH'(1);
      x <= '0;
      v <= '0;
      w <= eeg_pkg::COEF_WIDTH'(1);
    end else if (state == eeg_pkg::ST_UPDATE) begin
      g <= y;
      y <= div_rem;
      u <= x;
      x <= u - x_prod;
      v <= w;
      w <= v - w_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      gcd_value <= g;
      coef_a    <= u;
      coef_b    <= v;
    end
  end

  `EEG_ASSERT_NOW(a_done_in_div, clk, rst, div_sts.done, state == eeg_pkg::ST_DIV, "divider finished outside of the divide state")
  `EEG_ASSERT_NOW(a_start_idle, clk, rst, state == eeg_pkg::ST_START, !div_sts.busy && y != '0, "divider started while busy or with a zero divisor")
  `EEG_ASSERT_NEXT(a_last_step, clk, rst, state == eeg_pkg::ST_UPDATE && div_rem == '0, state == eeg_pkg::ST_DONE, "zero remainder did not end the loop")
  `EEG_ASSERT_NEXT(a_take_busy, clk, rst, in_take, state != eeg_pkg::ST_IDLE, "accepted word left the sequencer idle")

endmodule

### dv/extended_euclid_gcd_checker.sv
// Checker that predicts and compares every result word of the gcd block.
`timescale 1ns / 1ps

module extended_euclid_gcd_checker #(
  parameter int OPERAND_WIDTH = eeg_pkg::DEF_OPERAND_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic [OPERAND_WIDTH-1:0]              a_value,
  input  logic [OPERAND_WIDTH-1:0]              b_value,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [OPERAND_WIDTH-1:0]              gcd_value,
  input  logic signed [eeg_pkg::COEF_WIDTH-1:0] coef_a,
  input  logic signed [eeg_pkg::COEF_WIDTH-1:0] coef_b,
  output int                                    fail_count,
  output int                                    pending_words,
  output int                                    result_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0]        gcd;
    logic [eeg_pkg::COEF_WIDTH-1:0]  ca;
    logic [eeg_pkg::COEF_WIDTH-1:0]  cb;
  } bezout_t;

  bezout_t bezout_q[$];

  // The recurrence runs on 64-bit values, so the coefficients wrap the same
  // way for any operand width; b of zero falls out of the loop directly.
  function automatic bezout_t solve_bezout(logic [OPERAND_WIDTH-1:0] a,
                                           logic [OPERAND_WIDTH-1:0] b);
    logic [63:0] g, y, q, r, u, x, v, w, t;
    bezout_t res;
    g = 64'(a);
    y = 64'(b);
    u = 64'd1;
    x = 64'd0;
    v = 64'd0;
    w = 64'd1;
    while (y != 64'd0) begin
      q = g / y;
      r = g % y;
      t = u - q * x;
      u = x;
      x = t;
      t = v - q * w;
      v = w;
      w = t;
      g = y;
      y = r;
    end
    res.gcd = g[OPERAND_WIDTH-1:0];
    res.ca = u[eeg_pkg::COEF_WIDTH-1:0];
    res.cb = v[eeg_pkg::COEF_WIDTH-1:0];
    return res;
  endfunction

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what,
               $signed(want), $signed(got));
    end
  endfunction

  initial begin
    fail_count = 0;
    pending_words = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    bezout_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (bezout_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: result word with none expected, gcd %0d", $time, gcd_value);
          end
        end else begin
          want = bezout_q.pop_front();
          if (gcd_value !== want.gcd) begin
            note_mismatch("gcd_value", 64'(want.gcd), 64'(gcd_value));
          end
          if (coef_a !== want.ca) begin
            note_mismatch("coef_a", 64'($signed(want.ca)), 64'(coef_a));
          end
          if (coef_b !== want.cb) begin
            note_mismatch("coef_b", 64'($signed(want.cb)), 64'(coef_b));
          end
        end
      end
      if (in_valid && !in_stall) begin
        bezout_q = {bezout_q, solve_bezout(a_value, b_value)};
      end
      pending_words = bezout_q.size();
    end
  end

endmodule

### dv/extended_euclid_gcd_test.sv
// Top of the gcd block testbench: clock, reset, operand stimulus and verdict.
`timescale 1ns / 1ps

module extended_euclid_gcd_test;

  localparam int W = eeg_pkg::DEF_OPERAND_WIDTH;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 94;
  localparam logic [W-1:0] MAXV = '1;
  localparam logic [W-1:0] FIB45 = W'(1134903170);
  localparam logic [W-1:0] FIB46 = W'(1836311903);

  logic                                  clk;
  logic                                  rst;
  logic                                  in_valid;
  logic                                  in_stall;
  logic [W-1:0]                          a_value;
  logic [W-1:0]                          b_value;
  logic                                  out_valid;
  logic                                  out_stall;
  logic [W-1:0]                          gcd_value;
  logic signed [eeg_pkg::COEF_WIDTH-1:0] coef_a;
  logic signed [eeg_pkg::COEF_WIDTH-1:0] coef_b;

  int fail_count;
  int pending_words;
  int result_count;
  int send_idle_pct;
  int recv_stall_pct;
  int words_sent;
  int stalled_cycles;

  extended_euclid_gcd #(.OPERAND_WIDTH(W)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_value(a_value), .b_value(b_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .gcd_value(gcd_value), .coef_a(coef_a), .coef_b(coef_b)
  );

  extended_euclid_gcd_checker #(.OPERAND_WIDTH(W)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_value(a_value), .b_value(b_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .gcd_value(gcd_value), .coef_a(coef_a), .coef_b(coef_b),
    .fail_count(fail_count), .pending_words(pending_words),
    .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99, 0) < recv_stall_pct);
  end

  initial begin
    stalled_cycles = 0;
    while (stalled_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  task automatic send_word(input logic [W-1:0] a, input logic [W-1:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    a_value <= a;
    b_value <= b;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic logic [W-1:0] random_operand();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return W'($urandom_range(255, 1));
      2: return MAXV - W'($urandom_range(3, 0));
      default: return W'($urandom());
    endcase
  endfunction

  // Mix of unrelated operands, operands sharing a factor and plain noise.
  task automatic send_random_words(input int count);
    logic [W-1:0] a, b;
    int unsigned factor;
    repeat (count) begin
      if ($urandom_range(3, 0) == 0) begin
        factor = $urandom_range(65535, 2);
        a = W'(factor * $urandom_range(int'(MAXV) / factor, 0));
        b = W'(factor * $urandom_range(int'(MAXV) / factor, 0));
      end else begin
        a = random_operand();
        b = random_operand();
      end
      send_word(a, b);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    a_value = '0;
    b_value = '0;
    send_idle_pct = 8;
    recv_stall_pct = 53;
    words_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_word('0, '0);
    send_word('0, W'(7));
    send_word(W'(9), '0);
    send_word(MAXV, '0);
    send_word('0, MAXV);
    send_word(MAXV, MAXV);
    send_word(MAXV, W'(1));
    send_word(W'(1), MAXV);
    send_word(W'(1), W'(1));
    send_word(W'(1), '0);
    send_word(FIB46, FIB45);
    send_word(FIB45, FIB46);
    send_word(MAXV, MAXV - W'(1));
    send_word(W'(240), W'(46));
    send_word(W'(12), W'(18));
    send_word(W'(1) << (W - 1), W'(1) << (W - 2));
    send_word(W'(1) << (W - 1), W'(3));
    send_word(W'(1000000007), W'(998244353));
    send_word(MAXV, W'(1) << (W - 1));
    send_word(W'(5) << 20, W'(7) << 18);
    drain_results();
    @(negedge clk);

    send_random_words(RANDOM_PER_PHASE);
    drain_results();
    @(negedge clk);

    send_idle_pct = 53;
    recv_stall_pct = 8;
    send_random_words(RANDOM_PER_PHASE);
    drain_results();
    @(negedge clk);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random_words(RANDOM_PER_PHASE);
    drain_results();
    repeat (40) @(negedge clk);

    $display("Sent %0d operand words and checked %0d result words under three idle mixes,",
             words_sent, result_count);
    $display("including zero operands, full-scale values and consecutive Fibonacci pairs.");
    if (fail_count == 0 && pending_words == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
